### rtl/fcca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcca_pkg
// Shared types, constants and helpers for the FAT12 cluster chain allocator.
// ----------------------------------------------------------------------------
package fcca_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int LIM_W       = $clog2(TABLE_DEPTH + 1);
	localparam int FIRST_DATA  = 2;
	localparam logic [11:0] END_MARK = 12'hFFF;

	localparam logic [2:0] ACT_ALLOC = 3'd0;
	localparam logic [2:0] ACT_FREE  = 3'd1;
	localparam logic [2:0] ACT_LEN   = 3'd2;
	localparam logic [2:0] ACT_WRITE = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;

	localparam logic CFG_TOTAL = 1'b0;
	localparam logic CFG_LOG2  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_NEED,
		ST_WALK_RD,
		ST_WALK_USE,
		ST_COUNT,
		ST_CHECK,
		ST_FIT,
		ST_FIT_END,
		ST_READ_USE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [11:0] cluster_index;
		logic [23:0] file_bytes;
		logic [11:0] entry_word;
	} in_item_t;

	typedef struct packed {
		logic        status;
		logic [11:0] first_cluster;
		logic [11:0] cluster_run;
		logic [11:0] read_word;
		logic [11:0] free_total;
	} out_item_t;

	function automatic logic [11:0] fit12(input logic [LIM_W-1:0] v);
		logic [LIM_W+11:0] w;
		w = {12'd0, v};
		return w[11:0];
	endfunction

endpackage

### rtl/fcca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcca_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fcca_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/fat_cluster_chain_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_cluster_chain_allocator
// FAT12 allocation table with chain allocate, free, length and entry access.
// ----------------------------------------------------------------------------
// Every action ends with a sweep that counts the unused clusters. Free and length first
// walk the chain; allocate walks the old chain, counts and checks the need, and if it fits
// frees the old chain, fits the new one and counts again. Read fetches the entry first.
// One transaction at a time, the next accepted in the cycle after the result loads.
// After reset a clearing pass writes every one of the 1024 entries to zero,
// one per cycle, and in_stall stays high until the pass is done.
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator
	import fcca_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [9:0]  cfg_wdata
);

	state_t state_q, state_d;

	logic [9:0]        cfg_total_q;
	logic [3:0]        cfg_log2_q;
	logic [ADDR_W-1:0] clr_q;
	in_item_t          item_q;
	logic [11:0]       cur_q;
	logic [LIM_W-1:0]  n_q, oldlen_q, free_q, scan_q, taken_q, run_q;
	logic [ADDR_W-1:0] prev_q, pend_q;
	logic              p_q, release_q, post_q, status_q;
	logic [11:0]       first_q, rd_q;
	logic [24:0]       need_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [11:0]       ram_wdata, ram_rdata;

	logic [15:0]       lim_sum, lim16, usable16, cap16;
	logic [LIM_W-1:0]  cap;
	logic              walk_go, count_issue, fit_issue, fit_take;
	logic              in_acc, idx_in_table, load_out;
	logic [24:0]       csz_m1, need_d;

	fcca_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(12)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign lim_sum  = 16'(cfg_total_q) + 16'(FIRST_DATA);
	assign lim16    = (lim_sum > 16'(TABLE_DEPTH)) ? 16'(TABLE_DEPTH) : lim_sum;
	assign usable16 = (lim16 > 16'(FIRST_DATA)) ? lim16 - 16'(FIRST_DATA) : 16'd0;
	assign cap16    = usable16 + 16'd2;
	assign cap      = cap16[LIM_W-1:0];

	assign walk_go = (16'(cur_q) >= 16'(FIRST_DATA)) && (16'(cur_q) < lim16) &&
		(n_q < cap);
	assign count_issue = 16'(scan_q) < lim16;
	assign fit_issue   = count_issue && (25'(taken_q) < need_q);
	assign fit_take    = p_q && (25'(taken_q) < need_q) && (ram_rdata == 12'd0);

	assign in_stall     = (state_q != ST_IDLE);
	assign in_acc       = in_valid && !in_stall;
	assign idx_in_table = 16'(in_data.cluster_index) < 16'(TABLE_DEPTH);
	assign load_out     = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign csz_m1 = (25'd1 << cfg_log2_q) - 25'd1;
	assign need_d = (25'(item_q.file_bytes) + csz_m1) >> cfg_log2_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(TABLE_DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc) begin
					case (in_data.action)
						ACT_ALLOC: state_d = ST_NEED;
						ACT_FREE, ACT_LEN: state_d = ST_WALK_RD;
						ACT_READ: state_d = idx_in_table ? ST_READ_USE : ST_COUNT;
						default: state_d = ST_COUNT;
					endcase
				end
			end
			ST_NEED: state_d = ST_WALK_RD;
			ST_WALK_RD: begin
				if (walk_go) begin
					state_d = ST_WALK_USE;
				end else if (item_q.action == ACT_ALLOC && release_q) begin
					state_d = ST_FIT;
				end else begin
					state_d = ST_COUNT;
				end
			end
			ST_WALK_USE: state_d = ST_WALK_RD;
			ST_COUNT: begin
				if (!p_q && !count_issue) state_d = post_q ? ST_DONE : ST_CHECK;
			end
			ST_CHECK: begin
				if (need_q > 25'(free_q) + 25'(oldlen_q)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_WALK_RD;
				end
			end
			ST_FIT: begin
				if (!p_q && !fit_issue) state_d = ST_FIT_END;
			end
			ST_FIT_END: state_d = ST_COUNT;
			ST_READ_USE: state_d = ST_COUNT;
			ST_DONE: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_IDLE: begin
				if (in_acc && idx_in_table) begin
					ram_raddr = in_data.cluster_index[ADDR_W-1:0];
					if (in_data.action == ACT_WRITE) begin
						ram_we    = 1'b1;
						ram_waddr = in_data.cluster_index[ADDR_W-1:0];
						ram_wdata = in_data.entry_word;
					end
				end
			end
			ST_WALK_RD: begin
				ram_raddr = cur_q[ADDR_W-1:0];
			end
			ST_WALK_USE: begin
				if (release_q) begin
					ram_we    = 1'b1;
					ram_waddr = cur_q[ADDR_W-1:0];
				end
			end
			ST_COUNT: begin
				ram_raddr = scan_q[ADDR_W-1:0];
			end
			ST_FIT: begin
				ram_raddr = scan_q[ADDR_W-1:0];
				if (fit_take && prev_q != '0) begin
					ram_we    = 1'b1;
					ram_waddr = prev_q;
					ram_wdata = 12'(pend_q);
				end
			end
			ST_FIT_END: begin
				if (prev_q != '0) begin
					ram_we    = 1'b1;
					ram_waddr = prev_q;
					ram_wdata = END_MARK;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cfg_total_q <= 10'd354;
			cfg_log2_q  <= 4'd10;
			out_valid_q <= 1'b0;
			p_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TOTAL: cfg_total_q <= cfg_wdata;
					CFG_LOG2:  cfg_log2_q  <= cfg_wdata[3:0];
					default: begin
					end
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if ((state_d == ST_COUNT && state_q != ST_COUNT) ||
				(state_d == ST_FIT && state_q != ST_FIT)) begin
				p_q <= 1'b0;
			end else if (state_q == ST_COUNT) begin
				p_q <= count_issue;
			end else if (state_q == ST_FIT) begin
				p_q <= fit_issue;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.status        <= status_q;
			out_q.first_cluster <= first_q;
			out_q.cluster_run   <= fit12(run_q);
			out_q.read_word     <= rd_q;
			out_q.free_total    <= fit12(free_q);
		end
		if ((state_d == ST_COUNT && state_q != ST_COUNT) ||
			(state_d == ST_FIT && state_q != ST_FIT)) begin
			scan_q  <= LIM_W'(FIRST_DATA);
			free_q  <= '0;
			taken_q <= '0;
			prev_q  <= '0;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					item_q    <= in_data;
					cur_q     <= in_data.cluster_index;
					n_q       <= '0;
					oldlen_q  <= '0;
					release_q <= (in_data.action == ACT_FREE);
					post_q    <= (in_data.action != ACT_ALLOC);
					status_q  <= 1'b0;
					first_q   <= '0;
					run_q     <= '0;
					rd_q      <= '0;
				end
			end
			ST_NEED: need_q <= need_d;
			ST_WALK_RD: begin
				if (!walk_go) begin
					if (item_q.action == ACT_ALLOC) begin
						if (!release_q) oldlen_q <= n_q;
					end else begin
						run_q <= n_q;
					end
				end
			end
			ST_WALK_USE: begin
				cur_q <= ram_rdata;
				n_q   <= n_q + 1'b1;
			end
			ST_COUNT: begin
				if (count_issue) begin
					scan_q <= scan_q + 1'b1;
				end
				if (p_q && ram_rdata == 12'd0) free_q <= free_q + 1'b1;
			end
			ST_CHECK: begin
				if (need_q > 25'(free_q) + 25'(oldlen_q)) begin
					status_q <= 1'b1;
				end else begin
					release_q <= 1'b1;
					post_q    <= 1'b1;
					cur_q     <= item_q.cluster_index;
					n_q       <= '0;
				end
			end
			ST_FIT: begin
				if (fit_issue) begin
					scan_q <= scan_q + 1'b1;
					pend_q <= scan_q[ADDR_W-1:0];
				end
				if (fit_take) begin
					if (prev_q == '0) first_q <= 12'(pend_q);
					prev_q  <= pend_q;
					taken_q <= taken_q + 1'b1;
				end
			end
			ST_FIT_END: run_q <= taken_q;
			ST_READ_USE: rd_q <= ram_rdata;
			default: begin
			end
		endcase
	end

endmodule

### rtl/fcca_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcca_checker
// Port-level checks for the cluster chain allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fcca_checker
	import fcca_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a transaction is in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a transaction in progress");

	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |->
			out_data.first_cluster == 12'd0 && out_data.cluster_run == 12'd0)
		else $error("failed allocate reports a chain");

endmodule

bind fat_cluster_chain_allocator fcca_checker u_fcca_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

### tb/fat_cluster_chain_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_cluster_chain_allocator_tb
// Drives allocate, free, length, entry write/read and spare actions into the
// allocator under random valid and stall gaps and several volume geometries.
// A mirror of the allocation table predicts every reply, and each accepted
// reply is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator_tb;
	import fcca_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 3000;
	localparam int MAX_REPORTS    = 10;
	localparam int PAUSE_PCT      = 2;
	localparam int HEADS_KEPT     = 32;
	localparam int RESET_TOTAL    = 354;
	localparam int RESET_LOG2     = 10;
	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
	localparam int PHASES = 6;

	class fat_table_mirror;
		logic [11:0]  fat [TABLE_DEPTH];
		int unsigned  total_clusters;
		int unsigned  size_log2;
		out_item_t    replies_due[$];
		logic [11:0]  chain_heads[$];
		int unsigned  mismatches;

		function new();
			foreach (fat[i]) fat[i] = '0;
			total_clusters = RESET_TOTAL;
			size_log2 = RESET_LOG2;
			mismatches = 0;
		endfunction

		function void set_geometry(logic [9:0] total, logic [3:0] log2v);
			total_clusters = total;
			size_log2 = log2v;
		endfunction

		function int unsigned data_end();
			int unsigned lim;
			lim = total_clusters + FIRST_DATA;
			if (lim > TABLE_DEPTH) lim = TABLE_DEPTH;
			return lim;
		endfunction

		function int unsigned walk_cap();
			int unsigned lim;
			lim = data_end();
			return (lim > FIRST_DATA ? lim - FIRST_DATA : 0) + 2;
		endfunction

		function bit is_data(int unsigned c);
			return c >= FIRST_DATA && c < data_end();
		endfunction

		function int unsigned count_unused();
			int unsigned n;
			n = 0;
			for (int unsigned c = FIRST_DATA; c < data_end(); c++)
				if (fat[c] == 0) n++;
			return n;
		endfunction

		function int unsigned chain_steps(int unsigned start);
			int unsigned n, c, cap;
			n = 0;
			c = start;
			cap = walk_cap();
			while (is_data(c) && n < cap) begin
				n++;
				c = fat[c];
			end
			return n;
		endfunction

		function int unsigned drop_chain(int unsigned start);
			int unsigned n, c, nx, cap;
			n = 0;
			c = start;
			cap = walk_cap();
			while (is_data(c) && n < cap) begin
				nx = fat[c];
				fat[c] = '0;
				n++;
				c = nx;
			end
			return n;
		endfunction

		function logic [11:0] pick_head();
			if (chain_heads.size() == 0) return '0;
			return chain_heads[$urandom_range(chain_heads.size() - 1)];
		endfunction

		function void accept_action(in_item_t req);
			out_item_t   want;
			int unsigned csz, need, prev, taken, lim;
			want = '0;
			case (req.action)
				ACT_ALLOC: begin
					csz = 32'd1 << size_log2;
					need = (32'(req.file_bytes) + csz - 1) >> size_log2;
					if (need > count_unused() + chain_steps(req.cluster_index)) begin
						want.status = 1'b1;
					end else begin
						void'(drop_chain(req.cluster_index));
						prev = 0;
						taken = 0;
						lim = data_end();
						for (int unsigned c = FIRST_DATA; c < lim && taken < need; c++) begin
							if (fat[c] == 0) begin
								fat[c] = END_MARK;
								if (prev != 0) fat[prev] = 12'(c);
								else want.first_cluster = 12'(c);
								prev = c;
								taken++;
							end
						end
						want.cluster_run = 12'(taken);
						if (want.first_cluster != 0) begin
							chain_heads.push_back(want.first_cluster);
							if (chain_heads.size() > HEADS_KEPT) void'(chain_heads.pop_front());
						end
					end
				end
				ACT_FREE: want.cluster_run = 12'(drop_chain(req.cluster_index));
				ACT_LEN: want.cluster_run = 12'(chain_steps(req.cluster_index));
				ACT_WRITE: if (req.cluster_index < TABLE_DEPTH) fat[req.cluster_index] = req.entry_word;
				ACT_READ: if (req.cluster_index < TABLE_DEPTH) want.read_word = fat[req.cluster_index];
				default: ;
			endcase
			want.free_total = 12'(count_unused());
			replies_due.push_back(want);
		endfunction

		function void check_reply(out_item_t got);
			out_item_t want;
			if (replies_due.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t: reply with none pending: st=%0d first=%0d run=%0d rd=%h free=%0d",
						$time, got.status, got.first_cluster, got.cluster_run, got.read_word,
						got.free_total);
				mismatches++;
				return;
			end
			want = replies_due.pop_front();
			if (got.status !== want.status || got.first_cluster !== want.first_cluster ||
				got.cluster_run !== want.cluster_run || got.read_word !== want.read_word ||
				got.free_total !== want.free_total) begin
				if (mismatches < MAX_REPORTS) begin
					$display("%0t: mismatch exp st=%0d first=%0d run=%0d rd=%h free=%0d", $time,
						want.status, want.first_cluster, want.cluster_run, want.read_word,
						want.free_total);
					$display("%0t:          got st=%0d first=%0d run=%0d rd=%h free=%0d", $time,
						got.status, got.first_cluster, got.cluster_run, got.read_word,
						got.free_total);
				end
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_TOTAL;
	logic [9:0]  cfg_wdata = '0;

	fat_table_mirror mirror = new();
	int unsigned send_idle_pct = 31;
	int unsigned recv_idle_pct = 64;
	int unsigned quiet_cycles = 0;

	fat_cluster_chain_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) mirror.check_reply(out_data);
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[fat_cluster_chain_allocator] ERROR");
			$finish;
		end
	end

	task automatic push_request(input in_item_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		mirror.accept_action(req);
	endtask

	task automatic issue(input logic [2:0] act, input logic [11:0] idx,
		input logic [23:0] bytes, input logic [11:0] word);
		in_item_t req;
		req.action = act;
		req.cluster_index = idx;
		req.file_bytes = bytes;
		req.entry_word = word;
		push_request(req);
	endtask

	task automatic wait_replies_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (mirror.replies_due.size() != 0) @(posedge clk);
	endtask

	task automatic program_volume(input logic [9:0] total, input logic [9:0] log2v);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TOTAL;
		cfg_wdata <= total;
		@(posedge clk);
		cfg_index <= CFG_LOG2;
		cfg_wdata <= log2v;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror.set_geometry(total, log2v[3:0]);
	endtask

	function automatic logic [11:0] chain_start_pick(int unsigned span);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 70) return mirror.pick_head();
		if (pick < 90) return 12'($urandom_range(span + 1));
		return 12'($urandom);
	endfunction

	function automatic in_item_t next_random_action();
		in_item_t    req;
		int unsigned roll, pick, span, csz;
		req.action = ACT_ALLOC;
		req.cluster_index = 12'($urandom);
		req.file_bytes = 24'($urandom);
		req.entry_word = 12'($urandom);
		span = mirror.data_end();
		roll = $urandom_range(99);
		if (roll < 38) begin
			pick = $urandom_range(99);
			if (pick < 50) req.cluster_index = mirror.pick_head();
			else if (pick < 75) req.cluster_index = '0;
			else if (pick < 95) req.cluster_index = 12'($urandom_range(span + 1));
			csz = 32'd1 << mirror.size_log2;
			pick = $urandom_range(99);
			if (pick < 10) req.file_bytes = '0;
			else if (pick < 40)
				req.file_bytes = 24'($urandom_range(8, 1) * csz + $urandom_range(2) - 1);
			else if (pick >= 50) req.file_bytes = 24'($urandom_range(6 * csz, 1));
		end else if (roll < 53) begin
			req.action = ACT_FREE;
			req.cluster_index = chain_start_pick(span);
		end else if (roll < 71) begin
			req.action = ACT_LEN;
			req.cluster_index = chain_start_pick(span);
		end else if (roll < 86) begin
			req.action = ACT_WRITE;
			pick = $urandom_range(99);
			if (pick < 60) req.cluster_index = 12'($urandom_range(span + 2));
			else if (pick < 75) req.cluster_index = 12'($urandom_range(1));
			pick = $urandom_range(99);
			if (pick < 35) req.entry_word = 12'($urandom_range(span - 1, FIRST_DATA));
			else if (pick < 55) req.entry_word = '0;
			else if (pick < 70) req.entry_word = END_MARK;
			else if (pick < 85) req.entry_word = req.cluster_index;
		end else if (roll < 96) begin
			req.action = ACT_READ;
			if ($urandom_range(99) < 75) req.cluster_index = 12'($urandom_range(span + 2));
		end else begin
			req.action = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
		end
		return req;
	endfunction

	task automatic run_directed();
		issue(ACT_READ, 12'd0, 24'd0, 12'd0);
		issue(ACT_ALLOC, 12'd0, 24'd0, 12'd0);
		issue(ACT_ALLOC, 12'hFFF, 24'd1, 12'd0);
		issue(ACT_ALLOC, 12'd0, 24'd1024, 12'd0);
		issue(ACT_ALLOC, 12'd0, 24'd1025, 12'd0);
		issue(ACT_LEN, 12'd4, 24'd0, 12'd0);
		issue(ACT_ALLOC, 12'd0, 24'hFFFFFF, 12'hFFF);
		issue(ACT_ALLOC, 12'd4, 24'd3000, 12'd0);
		issue(ACT_FREE, 12'd2, 24'hFFFFFF, 12'd0);
		issue(ACT_FREE, 12'd0, 24'd0, 12'd0);
		issue(ACT_FREE, 12'hFFF, 24'd0, 12'd0);
		issue(ACT_WRITE, 12'hFFF, 24'd0, 12'hABC);
		issue(ACT_READ, 12'hFFF, 24'd0, 12'd0);
		issue(ACT_WRITE, 12'd1, 24'd0, END_MARK);
		issue(ACT_READ, 12'd1, 24'd0, 12'd0);
		issue(ACT_WRITE, 12'd0, 24'd0, 12'h555);
		issue(ACT_READ, 12'd0, 24'd0, 12'd0);
		issue(ACT_WRITE, 12'd300, 24'd0, 12'd300);
		issue(ACT_LEN, 12'd300, 24'd0, 12'd0);
		issue(ACT_ALLOC, 12'd300, 24'((mirror.count_unused() + 100) << mirror.size_log2),
			12'd0);
		issue(ACT_ALLOC, 12'd0, 24'd1, 12'd0);
		issue(ACT_WRITE, 12'd1000, 24'd0, 12'h00F);
		issue(ACT_READ, 12'd1000, 24'd0, 12'd0);
		issue(ACT_FREE, 12'd2, 24'd0, 12'd0);
		issue(ACT_SPARE_LAST, 12'hFFF, 24'hFFFFFF, 12'hFFF);
	endtask

	initial begin
		int unsigned phase_total [PHASES];
		int unsigned phase_log2 [PHASES];
		int unsigned phase_items [PHASES];
		int unsigned phase_send [PHASES];
		int unsigned phase_recv [PHASES];
		phase_total = '{1, 1022, 40, 100, 1022, 17};
		phase_log2  = '{9, 15, 9, 12, 9, 11};
		phase_items = '{40, 50, 160, 160, 40, 120};
		phase_send  = '{31, 31, 64, 64, 0, 0};
		phase_recv  = '{64, 64, 31, 31, 0, 0};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		for (int p = 0; p < PHASES; p++) begin
			wait_replies_drained();
			repeat (SETTLE_CYCLES) @(posedge clk);
			program_volume(10'(phase_total[p]), 10'(phase_log2[p]));
			send_idle_pct = phase_send[p];
			recv_idle_pct = phase_recv[p];
			for (int n = 0; n < phase_items[p]; n++) begin
				if ($urandom_range(99) < PAUSE_PCT) wait_replies_drained();
				push_request(next_random_action());
			end
		end
		wait_replies_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.replies_due.size() == 0) begin
			$display("[fat_cluster_chain_allocator] OK");
		end else begin
			$display("[fat_cluster_chain_allocator] ERROR");
		end
		$finish;
	end

endmodule

### files.f
rtl/fcca_pkg.sv
rtl/fcca_ram.sv
rtl/fat_cluster_chain_allocator.sv
rtl/fcca_checker.sv
tb/fat_cluster_chain_allocator_tb.sv
